// ===== hdl/sm3rf_pkg.sv =====
package sm3rf_pkg;

    localparam int ROUNDS = 32;
    localparam int NUM_ROUNDS = (ROUNDS > 64) ? 64 : ROUNDS;
    localparam int RND_W = 6;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // controller -> datapath
    typedef struct packed {
        logic       load_byte;   // write s_data_byte at fill pointer, bump count
        logic       load_pad;    // write padding byte at fill pointer
        logic       comp_start;  // load A..H from chain
        logic       comp_round;  // run one round
        logic       comp_end;    // fold A..H into chain
        logic       fold_load;   // capture fold code, reset chain and count
    } sm3rf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       block_full;  // fill pointer wraps after this write
        logic       round_last;
        logic       len_done;    // length field has been written
    } sm3rf_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== hdl/sm3rf_datapath.sv =====
module sm3rf_datapath
    import sm3rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sm3rf_cmd_t  cmd,
    input  logic [7:0]  in_byte,
    output sm3rf_sts_t  sts,
    output logic [31:0] fold_code
);

    logic [63:0] count_reg;
    logic [5:0]  ptr_reg;
    logic        wrap_reg;   // padding crossed into a second block
    logic        len_reg;    // length field written
    logic [31:0] chain_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16]; // message words, then the expansion window
    logic [RND_W-1:0] rnd_reg;
    logic [31:0] fold_reg;

    logic [63:0] bits;
    logic        len_ok;
    logic [7:0]  pad_val;
    logic [7:0]  wr_byte;
    logic [31:0] t_sel, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
    logic [3:0]  j0, j3, j4, j7, j10, j13;
    logic [7:0]  sums [4];

    assign bits   = count_reg << 3;
    assign len_ok = wrap_reg || (count_reg[5:0] < LEN_POS);

    always_comb begin
        if (!wrap_reg && ptr_reg == count_reg[5:0]) begin
            pad_val = PAD_BYTE;
        end else if (ptr_reg >= LEN_POS && len_ok) begin
            pad_val = bits[{~ptr_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_val = 8'h00;
        end
    end

    assign wr_byte = cmd.load_byte ? in_byte : pad_val;

    always_comb begin
        j0  = rnd_reg[3:0];
        j3  = rnd_reg[3:0] + 4'd3;
        j4  = rnd_reg[3:0] + 4'd4;
        j7  = rnd_reg[3:0] + 4'd7;
        j10 = rnd_reg[3:0] + 4'd10;
        j13 = rnd_reg[3:0] + 4'd13;
        t_sel = (rnd_reg < RND_W'(16)) ? T_LOW : T_HIGH;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(t_sel, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < RND_W'(16)) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[j0] ^ w_reg[j4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[j0];
        nw = perm1(w_reg[j0] ^ w_reg[j7] ^ rotl(w_reg[j13], 5'd15))
             ^ rotl(w_reg[j3], 5'd7) ^ w_reg[j10];
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sums[i] = chain_reg[2*i][31:24] + chain_reg[2*i][23:16]
                    + chain_reg[2*i][15:8] + chain_reg[2*i][7:0]
                    + chain_reg[2*i+1][31:24] + chain_reg[2*i+1][23:16]
                    + chain_reg[2*i+1][15:8] + chain_reg[2*i+1][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte || cmd.load_pad) begin
            w_reg[ptr_reg[5:2]][{~ptr_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end else if (cmd.comp_round) begin
            w_reg[j0] <= nw;
        end
        if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) begin
                r_reg[i] <= chain_reg[i];
            end
        end else if (cmd.comp_round) begin
            r_reg[3] <= r_reg[2];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= perm0(tt2);
        end
        if (cmd.fold_load) begin
            fold_reg <= {sums[0], sums[1], sums[2], sums[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ptr_reg   <= '0;
            rnd_reg   <= '0;
            wrap_reg  <= 1'b0;
            len_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= SM3_IV[255-32*i -: 32];
            end
        end else begin
            if (cmd.load_byte) begin
                count_reg <= count_reg + 64'd1;
                ptr_reg   <= ptr_reg + 6'd1;
            end else if (cmd.load_pad) begin
                ptr_reg <= ptr_reg + 6'd1;
                if (ptr_reg == 6'd63) begin
                    wrap_reg <= 1'b1;
                end
                if (ptr_reg >= LEN_POS && len_ok) begin
                    len_reg <= 1'b1;
                end
            end
            if (cmd.comp_start) begin
                rnd_reg <= '0;
            end else if (cmd.comp_round) begin
                rnd_reg <= rnd_reg + RND_W'(1);
            end
            if (cmd.comp_end) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] ^ r_reg[i];
                end
            end else if (cmd.fold_load) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= SM3_IV[255-32*i -: 32];
                end
                count_reg <= '0;
                ptr_reg   <= '0;
                wrap_reg  <= 1'b0;
                len_reg   <= 1'b0;
            end
        end
    end

    assign sts.block_full = (ptr_reg == 6'd63);
    assign sts.round_last = (rnd_reg == RND_W'(NUM_ROUNDS - 1));
    assign sts.len_done   = len_reg;
    assign fold_code      = fold_reg;

endmodule

// ===== hdl/sm3rf_ctrl.sv =====
module sm3rf_ctrl
    import sm3rf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_byte_present,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    input  sm3rf_sts_t sts,
    output sm3rf_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_END   = 6'b001000,
        ST_PAD   = 6'b010000,
        ST_FOLD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   pad_reg, pad_next;   // message is in padding phase
    logic   out_reg, out_next;   // result register holds a fold code
    logic   acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_reg;
    assign acc     = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        pad_next   = pad_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_byte_present) begin
                        cmd.load_byte = 1'b1;
                        pad_next = s_end_of_message;
                        if (sts.block_full) begin
                            state_next = ST_LOAD;
                        end else if (s_end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_end_of_message) begin
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.load_pad = 1'b1;
                if (sts.block_full) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.comp_start = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.comp_round = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                cmd.comp_end = 1'b1;
                if (!pad_reg) begin
                    state_next = ST_IDLE;
                end else if (sts.len_done) begin
                    state_next = ST_FOLD;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_FOLD: begin
                // hold until the result register is free
                if (!out_reg || m_ready) begin
                    cmd.fold_load = 1'b1;
                    pad_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        out_next = out_reg;
        if (out_reg && m_ready) begin
            out_next = 1'b0;
        end
        if (cmd.fold_load) begin
            out_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= 1'b0;
            out_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            out_reg   <= out_next;
        end
    end

endmodule

// ===== hdl/sm3_reduced_round_fold_hash.sv =====
// Reduced-round SM3 hash with a 4-byte fold.
// Input channel (s_valid/s_ready): one request per message byte. s_byte_present
// marks a real byte; s_end_of_message marks the last request, which may carry
// no byte. Output channel (m_valid/m_ready): one fold code per message.
// The 64th byte of a block starts a compression: a load step, 32 rounds (one
// round per cycle in a shared round unit) and a chaining step, during all of
// which s_ready is low.
// The final request writes the remaining padding bytes one per cycle up to the
// block end, compresses, and if the length did not fit, pads and compresses a
// second block; a final byte that fills a block is followed by a whole padding
// block. Then a fold step, and the result shows the cycle after.
// The result sits in an output register with m_valid high until m_ready, while
// new requests keep flowing; only the next fold cycle holds until that register
// is free, so a stalled receiver blocks input only at the next message end.
// Reset (aresetn low, synchronous) restores the SM3 IV, clears the byte count,
// drops any waiting result and returns to idle; the message words are not
// cleared.
module sm3_reduced_round_fold_hash
    import sm3rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_fold_code
);

    sm3rf_cmd_t cmd;
    sm3rf_sts_t sts;

    sm3rf_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_present  (s_byte_present),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .sts             (sts),
        .cmd             (cmd)
    );

    sm3rf_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_byte  (s_data_byte),
        .sts      (sts),
        .fold_code(m_fold_code)
    );

    // hold a stalled result steady
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fold_code))
        else $error("result changed while stalled");

    // a result follows the fold step
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.fold_load |=> m_valid)
        else $error("fold not followed by result");

    // datapath commands are mutually exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_byte, cmd.load_pad, cmd.comp_start, cmd.comp_round,
                  cmd.comp_end, cmd.fold_load}))
        else $error("conflicting datapath commands");

endmodule

// ===== tb/sm3_reduced_round_fold_hash_test.sv =====
`timescale 1ns / 100ps

// Fold-hash checker: keeps its own reduced-round SM3 state and predicts the
// fold code of every message as each request is accepted.
class fold_code_board;
    logic [31:0] chain[8];
    logic [7:0]  buffer[64];
    logic [63:0] count;
    logic [31:0] pending[$];
    int          errors;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        for (int k = 0; k < 8; k++) begin
            chain[k] = sm3rf_pkg::SM3_IV[255 - 32 * k -: 32];
        end
        count = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
        n = n & 31;
        if (n == 0) begin
            return x;
        end
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
        logic [31:0] w[16];
        logic [31:0] r[8];
        logic [31:0] wj, t, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
        for (int k = 0; k < 16; k++) begin
            w[k] = {buffer[4 * k], buffer[4 * k + 1], buffer[4 * k + 2], buffer[4 * k + 3]};
        end
        for (int k = 0; k < 8; k++) begin
            r[k] = chain[k];
        end
        for (int j = 0; j < sm3rf_pkg::NUM_ROUNDS; j++) begin
            wj = w[j & 15];
            t = (j < 16) ? sm3rf_pkg::T_LOW : sm3rf_pkg::T_HIGH;
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + rol(t, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end else begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (wj ^ w[(j + 4) & 15]);
            tt2 = gg + r[7] + ss1 + wj;
            r[3] = r[2];
            r[2] = rol(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rol(r[5], 19);
            r[5] = r[4];
            r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            nw = wj ^ w[(j + 7) & 15] ^ rol(w[(j + 13) & 15], 15);
            nw = nw ^ rol(nw, 15) ^ rol(nw, 23);
            w[j & 15] = nw ^ rol(w[(j + 3) & 15], 7) ^ w[(j + 10) & 15];
        end
        for (int k = 0; k < 8; k++) begin
            chain[k] ^= r[k];
        end
    endfunction

    function void note_request(logic [7:0] data, logic present, logic last);
        int          p;
        logic [63:0] bits;
        logic [7:0]  sum;
        logic [31:0] code;
        if (present) begin
            buffer[count[5:0]] = data;
            count++;
            if (count[5:0] == 0) begin
                compress();
            end
        end
        if (!last) begin
            return;
        end
        p = count[5:0];
        buffer[p] = sm3rf_pkg::PAD_BYTE;
        p++;
        if (p > 56) begin
            for (; p < 64; p++) begin
                buffer[p] = 8'h00;
            end
            compress();
            p = 0;
        end
        for (; p < 56; p++) begin
            buffer[p] = 8'h00;
        end
        bits = count << 3;
        for (int k = 0; k < 8; k++) begin
            buffer[56 + k] = bits[63 - 8 * k -: 8];
        end
        compress();
        for (int k = 0; k < 4; k++) begin
            sum = '0;
            for (int b = 0; b < 4; b++) begin
                sum += chain[2 * k][8 * b +: 8] + chain[2 * k + 1][8 * b +: 8];
            end
            code[31 - 8 * k -: 8] = sum;
        end
        pending.push_back(code);
        clear_state();
    endfunction

    function void check_code(logic [31:0] got);
        logic [31:0] want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected fold code %h", got));
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            report_mismatch($sformatf("fold code %h, want %h", got, want));
        end
    endfunction

    function void report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endfunction
endclass

module sm3_reduced_round_fold_hash_test;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_fold_code;

    // Percent chance per cycle that sender idles / receiver stalls.
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;
    fold_code_board board;

    sm3_reduced_round_fold_hash i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fold_code     (m_fold_code)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: stall at random, check every accepted fold code.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                board.check_code(m_fold_code);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("FAIL sm3_reduced_round_fold_hash");
                $finish;
            end
        end
    end

    // Present one request; idle first at random, hold until accepted.
    task automatic send_request(logic [7:0] data, logic present, logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < idle_pct);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= data;
        s_byte_present   <= present;
        s_end_of_message <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_request(data, present, last);
    endtask

    // Send one message of len random bytes; end with an empty request or on the last byte.
    task automatic send_message(int len, bit empty_end);
        for (int k = 0; k < len; k++) begin
            send_request(8'($urandom_range(255)), 1'b1, !empty_end && k == len - 1);
        end
        if (empty_end || len == 0) begin
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    // Drop valid and wait until every expected fold code has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Pick a length biased to the padding boundaries around 50..66 bytes.
    function automatic int pick_length();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            return $urandom_range(70);
        end else if (pick < 8) begin
            return 50 + $urandom_range(16);
        end
        return 100 + $urandom_range(100);
    endfunction

    int unsigned sent;

    initial begin
        board            = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data_byte      = '0;
        s_byte_present   = 1'b0;
        s_end_of_message = 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, idle request, byte-extreme values,
        // length-fit boundaries (55 fits, 56 needs a second block, 64 full).
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(63, 1'b0);
        send_message(64, 1'b1);
        send_message(64, 1'b0);
        drain();

        // Random messages across the idle/stall phases.
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            while (sent < (phase + 1) * 1240 / 4) begin
                int len;
                len = pick_length();
                if ($urandom_range(9) == 0) begin
                    send_request(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                send_message(len, 1'($urandom_range(1)));
                sent += len + 1;
                // Pause until the fold code has come back now and then.
                if ($urandom_range(7) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS sm3_reduced_round_fold_hash");
        end else begin
            $display("FAIL sm3_reduced_round_fold_hash");
        end
        $finish;
    end
endmodule
